// ===== hw/rtl/twlcg_pkg.sv =====
// Shared constants, payload types and controller codes for the twister generator.
package twlcg_pkg;

  localparam int unsigned WORD_COUNT = 624;
  localparam int unsigned TAP_OFFSET = 379;
  localparam int unsigned ADDR_W     = $clog2(WORD_COUNT);
  localparam int unsigned TAP_MOD    = TAP_OFFSET % WORD_COUNT;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] LCG_MUL   = 32'd2147001325;
  localparam logic [DATA_W-1:0] LCG_ADD   = 32'd715136305;
  localparam logic [DATA_W-1:0] FILL_XOR  = 32'h31415926;
  localparam logic [DATA_W-1:0] TWIST_XOR = 32'h9908B0DF;
  localparam logic [DATA_W-1:0] TEMPER_B  = 32'h9D2C5680;
  localparam logic [DATA_W-1:0] TEMPER_C  = 32'hEFC60000;

  typedef enum logic {
    ACT_SEED = 1'b0,
    ACT_DRAW = 1'b1
  } action_e;

  typedef struct packed {
    action_e            action;
    logic [31:0]        seed_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } in_t;

  typedef struct packed {
    logic [31:0]        raw_number;
    logic signed [31:0] ranged_number;
    logic               unseeded;
  } out_t;

  typedef enum logic [1:0] {
    ADDR_HERE,
    ADDR_NEXT,
    ADDR_TAP
  } addr_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_RD_HERE,
    ST_RD_NEXT,
    ST_RD_TAP,
    ST_TWIST,
    ST_TEMPER,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic      load_item;
    logic      seed_step;
    addr_sel_e rd_sel;
    logic      cap_top;
    logic      cap_low;
    logic      twist;
    logic      temper;
    logic      div_step;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic seeded;
    logic cnt_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/twlcg_ctrl.sv =====
// Sequencing state machine for seeding, twisting and the remainder loop.
module twlcg_ctrl import twlcg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  action_e in_action_i,
  input  sts_t    sts_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == ACT_SEED) begin
            state_d = ST_SEED;
          end else if (sts_i.seeded) begin
            state_d = ST_RD_HERE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SEED: begin
        if (sts_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_HERE: state_d = ST_RD_NEXT;
      ST_RD_NEXT: state_d = ST_RD_TAP;
      ST_RD_TAP:  state_d = ST_TWIST;
      ST_TWIST:   state_d = ST_TEMPER;
      ST_TEMPER:  state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.rd_sel = ADDR_HERE;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      ST_SEED:    cmd_o.seed_step = 1'b1;
      ST_RD_HERE: cmd_o.rd_sel = ADDR_HERE;
      ST_RD_NEXT: begin
        cmd_o.rd_sel  = ADDR_NEXT;
        cmd_o.cap_top = 1'b1;
      end
      ST_RD_TAP: begin
        cmd_o.rd_sel  = ADDR_TAP;
        cmd_o.cap_low = 1'b1;
      end
      ST_TWIST:  cmd_o.twist = 1'b1;
      ST_TEMPER: cmd_o.temper = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_DONE:   cmd_o.out_load = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/twlcg_dp.sv =====
// Word store, LCG fill, twist, tempering, serial remainder and result register.
module twlcg_dp import twlcg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_i,
  input  cmd_t cmd_i,
  input  logic out_stall_i,
  output sts_t sts_o,
  output logic out_valid_o,
  output out_t out_o
);

  function automatic logic [DATA_W-1:0] temper(input logic [DATA_W-1:0] w);
    logic [DATA_W-1:0] t;
    begin
      t = w ^ (w >> 11);
      t = t ^ ((t << 7) & TEMPER_B);
      t = t ^ ((t << 15) & TEMPER_C);
      t = t ^ (t >> 18);
      return t;
    end
  endfunction

  logic [DATA_W-1:0] mem_q [WORD_COUNT];
  logic [DATA_W-1:0] rd_data_q;

  logic [ADDR_W-1:0] pos_q;
  logic [ADDR_W-1:0] cnt_q;
  logic              seeded_q;
  logic [DATA_W-1:0] lcg_q;
  logic              out_valid_q;

  logic [DATA_W-1:0] lo_q;
  logic [DATA_W-1:0] span_q;
  logic              unseeded_q;
  logic              top_q;
  logic [DATA_W-2:0] low_q;
  logic [DATA_W-1:0] tw_q;
  logic [DATA_W-1:0] raw_q;
  logic [DATA_W-1:0] dvd_q;
  logic [DATA_W-1:0] rem_q;
  out_t              out_q;

  logic [ADDR_W-1:0] next_addr;
  logic [ADDR_W:0]   tap_sum;
  logic [ADDR_W-1:0] tap_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;
  logic [DATA_W-1:0] lcg_next;
  logic [DATA_W-1:0] fill_word;
  logic [DATA_W-1:0] twist_src;
  logic [DATA_W-1:0] twist_word;
  logic [DATA_W-1:0] tempered;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   span_ext;
  logic [DATA_W-1:0] rem_d;
  logic [DATA_W-1:0] range_sum;
  logic              out_free;
  out_t              out_d;

  assign next_addr = (pos_q == ADDR_W'(WORD_COUNT - 1)) ? '0 : pos_q + 1'b1;
  assign tap_sum   = {1'b0, pos_q} + (ADDR_W + 1)'(TAP_MOD);
  assign tap_addr  = (tap_sum >= (ADDR_W + 1)'(WORD_COUNT))
                   ? ADDR_W'(tap_sum - (ADDR_W + 1)'(WORD_COUNT))
                   : tap_sum[ADDR_W-1:0];

  always_comb begin
    case (cmd_i.rd_sel)
      ADDR_HERE: rd_addr = pos_q;
      ADDR_NEXT: rd_addr = next_addr;
      ADDR_TAP:  rd_addr = tap_addr;
      default:   rd_addr = pos_q;
    endcase
  end

  assign lcg_next  = lcg_q * LCG_MUL + LCG_ADD;
  assign fill_word = FILL_XOR ^ {lcg_next[DATA_W/2-1:0], lcg_next[DATA_W-1:DATA_W/2]};

  // The tap word is in the read register when the twist step runs.
  assign twist_src  = {top_q, low_q};
  assign twist_word = rd_data_q ^ (twist_src >> 1) ^ (twist_src[0] ? TWIST_XOR : '0);
  assign tempered   = temper(tw_q);

  assign wr_en   = cmd_i.seed_step | cmd_i.twist;
  assign wr_addr = cmd_i.seed_step ? cnt_q : pos_q;
  assign wr_data = cmd_i.seed_step ? fill_word : twist_word;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
  end

  // Restoring remainder, one dividend bit per step. A zero span always
  // subtracts nothing, so the remainder ends up as the raw word itself.
  assign trial    = {rem_q, dvd_q[DATA_W-1]};
  assign span_ext = {1'b0, span_q};
  assign rem_d    = (trial >= span_ext) ? DATA_W'(trial - span_ext) : trial[DATA_W-1:0];

  assign range_sum         = lo_q + rem_q;
  assign out_d.raw_number    = unseeded_q ? '0 : raw_q;
  assign out_d.ranged_number = unseeded_q ? '0 : $signed(range_sum);
  assign out_d.unseeded      = unseeded_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cnt_q       <= '0;
      seeded_q    <= 1'b0;
      lcg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.out_load | (out_valid_q & out_stall_i);
      if (cmd_i.load_item) begin
        cnt_q <= '0;
        if (in_i.action == ACT_SEED) begin
          lcg_q <= in_i.seed_value;
        end
      end else if (cmd_i.seed_step) begin
        lcg_q <= lcg_next;
        cnt_q <= cnt_q + 1'b1;
        if (sts_o.cnt_last) begin
          pos_q    <= '0;
          seeded_q <= 1'b1;
        end
      end else if (cmd_i.twist) begin
        pos_q <= next_addr;
      end else if (cmd_i.temper) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      lo_q       <= $unsigned(in_i.range_low);
      span_q     <= DATA_W'($unsigned(in_i.range_high) - $unsigned(in_i.range_low) + 1'b1);
      unseeded_q <= !seeded_q;
    end
    if (cmd_i.cap_top) begin
      top_q <= rd_data_q[DATA_W-1];
    end
    if (cmd_i.cap_low) begin
      low_q <= rd_data_q[DATA_W-2:0];
    end
    if (cmd_i.twist) begin
      tw_q <= twist_word;
    end
    if (cmd_i.temper) begin
      raw_q <= tempered;
      dvd_q <= tempered;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= dvd_q << 1;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign sts_o.seeded   = seeded_q;
  assign sts_o.cnt_last = (cnt_q == ADDR_W'(WORD_COUNT - 1));
  assign sts_o.div_last = (cnt_q[DIV_CNT_W-1:0] == DIV_CNT_W'(DATA_W - 1));
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== hw/rtl/twister_random_with_lcg_seeding.sv =====
// Seed item: the seed state writes one store word per cycle, stepping the LCG through every word of the store.
// Draw item: three single-port reads, twist, temper and a 32-step remainder loop run before the result is
// registered. An unseeded draw goes from acceptance straight to the done state.
// A new item is taken in the cycle after the result is loaded, while that result may still wait.
// Reset clears the position, the seeded flag, the LCG value and all control state; the word
// store is not cleared, since a seed writes every word before any draw reads one.
module twister_random_with_lcg_seeding import twlcg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  cmd_t cmd;
  sts_t sts;

  twlcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_i.action),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  twlcg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

`ifndef SYNTH
  // A result beat is never loaded over one that is still stalled.
  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded while previous beat still stalled");

  // An unseeded result carries zero numbers.
  a_unseeded_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.unseeded) |-> (out_o.raw_number == '0 && out_o.ranged_number == '0))
    else $error("unseeded result with non-zero numbers");

  // The word store is never written in a cycle that takes a new item.
  a_no_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !(cmd.seed_step || cmd.twist))
    else $error("store written while accepting an item");

  // A seed beat never produces a result in the following cycle.
  a_seed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_i.action == ACT_SEED) |=> !cmd.out_load)
    else $error("seed beat produced a result");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the twister generator with LCG seeding: seed and draw beats.
module tb_top;
  import twlcg_pkg::*;

  // Algorithm constants, kept apart from the package so that a wrong package value shows up.
  localparam int unsigned N_WORDS  = 624;
  localparam int unsigned TAP_DIST = 379;
  localparam logic [31:0] MUL_K    = 32'd2147001325;
  localparam logic [31:0] ADD_K    = 32'd715136305;
  localparam logic [31:0] FILL_K   = 32'h31415926;
  localparam logic [31:0] TWIST_K  = 32'h9908B0DF;
  localparam logic [31:0] TEMPER_B_K = 32'h9D2C5680;
  localparam logic [31:0] TEMPER_C_K = 32'hEFC60000;

  class twister_scoreboard;
    logic [31:0] words [N_WORDS];
    int unsigned pos;
    bit          seeded;
    logic [31:0] lcg;
    out_t        expected_draws [$];
    int unsigned failures;

    function new();
      pos      = 0;
      seeded   = 1'b0;
      lcg      = '0;
      failures = 0;
    endfunction

    // Updates the generator state for an accepted beat and queues the draw it yields.
    function void note_item(in_t item);
      logic [31:0] s;
      logic [31:0] r;
      logic [31:0] span;
      logic [31:0] lo_bits;
      logic [31:0] hi_bits;
      int unsigned nxt;
      int unsigned tap;
      out_t        draw_out;
      if (item.action == ACT_SEED) begin
        lcg = item.seed_value;
        for (int k = 0; k < N_WORDS; k++) begin
          lcg      = lcg * MUL_K + ADD_K;
          words[k] = FILL_K ^ {lcg[15:0], lcg[31:16]};
        end
        pos    = 0;
        seeded = 1'b1;
        return;
      end
      draw_out = '0;
      if (!seeded) begin
        draw_out.unseeded = 1'b1;
        expected_draws.push_back(draw_out);
        return;
      end
      nxt = (pos + 1 == N_WORDS) ? 0 : pos + 1;
      tap = (pos + TAP_DIST % N_WORDS) % N_WORDS;
      s   = {words[pos][31], words[nxt][30:0]};
      r   = words[tap] ^ (s >> 1) ^ (s[0] ? TWIST_K : 32'd0);
      words[pos] = r;
      pos = nxt;
      r = r ^ (r >> 11);
      r = r ^ ((r << 7) & TEMPER_B_K);
      r = r ^ ((r << 15) & TEMPER_C_K);
      r = r ^ (r >> 18);
      lo_bits = item.range_low;
      hi_bits = item.range_high;
      span    = hi_bits - lo_bits + 32'd1;
      draw_out.raw_number    = r;
      draw_out.ranged_number = lo_bits + ((span == 32'd0) ? r : r % span);
      expected_draws.push_back(draw_out);
    endfunction

    function void check_draw(out_t got);
      out_t want;
      if (expected_draws.size() == 0) begin
        $error("unexpected result beat: raw_number %h ranged_number %h unseeded %b",
               got.raw_number, got.ranged_number, got.unseeded);
        failures++;
        return;
      end
      want = expected_draws.pop_front();
      if (got.raw_number !== want.raw_number) begin
        $error("raw_number: expected %h, got %h", want.raw_number, got.raw_number);
        failures++;
      end
      if (got.ranged_number !== want.ranged_number) begin
        $error("ranged_number: expected %h, got %h", want.ranged_number, got.ranged_number);
        failures++;
      end
      if (got.unseeded !== want.unseeded) begin
        $error("unseeded: expected %b, got %b", want.unseeded, got.unseeded);
        failures++;
      end
    endfunction

    function int unsigned pending_count();
      return expected_draws.size();
    endfunction
  endclass

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;
  bit   idle_on   = 1'b1;

  twister_scoreboard sb = new();

  twister_random_with_lcg_seeding i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_draw(out_data);
    end
  end

  // Result-side back-pressure in short random bursts, only while idle_on is set.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Entered and left at a falling edge; the beat is noted at the edge that accepts it.
  task automatic send_item(input in_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
    sb.note_item(item);
    @(negedge clk_i);
  endtask

  task automatic send_seed(input logic [31:0] value);
    in_t item;
    item.action     = ACT_SEED;
    item.seed_value = value;
    item.range_low  = $urandom;
    item.range_high = $urandom;
    send_item(item);
  endtask

  task automatic send_draw(input logic [31:0] lo, input logic [31:0] hi);
    in_t item;
    item.action     = ACT_DRAW;
    item.seed_value = $urandom;
    item.range_low  = lo;
    item.range_high = hi;
    send_item(item);
  endtask

  task automatic random_draw();
    logic [31:0] lo;
    logic [31:0] hi;
    lo = $urandom;
    case ($urandom_range(0, 5))
      0: hi = $urandom;
      1: hi = lo + $urandom_range(0, 1000);
      2: hi = lo - 32'd1;                      // full 32-bit range, span wraps to zero
      3: hi = lo - $urandom_range(2, 1000);    // reversed bounds
      4: hi = lo + (32'd1 << $urandom_range(0, 31)) - 32'd1;
      default: hi = lo;
    endcase
    send_draw(lo, hi);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Draws before any seed must answer with zeros and the unseeded flag.
    send_draw(32'h80000000, 32'h7FFFFFFF);
    send_draw(32'd5, -32'sd5);
    send_seed(32'h00000000);
    send_draw(32'h80000000, 32'h7FFFFFFF);
    send_draw(32'h00000000, 32'hFFFFFFFF);
    send_draw(32'd7, 32'd7);
    send_draw(32'd100, -32'sd100);
    send_draw(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_draw(32'h80000000, 32'h80000000);
    send_draw(32'h00000000, 32'h7FFFFFFF);
    send_draw(32'h80000000, 32'h00000000);
    send_draw(32'hFFFFFFFF, 32'h00000000);
    send_seed(32'hFFFFFFFF);
    send_draw(32'h7FFFFFFF, 32'h80000000);
    send_draw(32'd1, 32'd0);
    send_seed(32'h80000000);
    send_draw(32'd0, 32'd9);
    send_seed(32'h7FFFFFFF);
    send_draw(-32'sd1000, 32'sd1000);

    // One seed followed by enough draws to carry the tap round the end of the store.
    send_seed($urandom);
    for (int i = 0; i < 440; i++) begin
      if (i == 200) begin
        idle_on = 1'b0;
      end
      if (i == 300) begin
        idle_on  = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk_i); while (sb.pending_count() != 0);
      end
      random_draw();
    end

    // Mixed seeds and draws; the final stretch runs without idling.
    for (int i = 0; i < 80; i++) begin
      if (i == 40) begin
        idle_on = 1'b0;
      end
      if ($urandom_range(0, 11) == 0) begin
        send_seed($urandom);
      end else begin
        random_draw();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #600_000;
    $display("status: fail");
    $finish;
  end

endmodule
